FILE: rtl/core/transpose_self_organizing_list_core_macros.svh
// Assertion macros shared by the transpose self-organizing list RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef TRANSPOSE_SELF_ORGANIZING_LIST_CORE_MACROS_SVH
`define TRANSPOSE_SELF_ORGANIZING_LIST_CORE_MACROS_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent holds.
`define TSOL_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("tsol: same-cycle assertion failed");

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define TSOL_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("tsol: next-cycle assertion failed");

`endif

FILE: rtl/core/tsol_pkg.sv
// Package for the transpose self-organizing list: operation and status codes,
// the stored entry type and the result type. No dependencies.
package tsol_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // One list entry as held in the entry memory.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] cnt;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hit_count;
  } res_t;

endpackage

FILE: rtl/core/tsol_if.sv
// Valid/ready channel interfaces for the request and result sides of the list.
// Depends on nothing; a transfer happens when valid and ready are both high.
interface tsol_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

interface tsol_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] hit_count;

  modport source (output valid, output status, output hit_count, input ready);
  modport sink (input valid, input status, input hit_count, output ready);
endinterface

FILE: rtl/core/tsol_ram.sv
// Single-write, single-read entry memory with registered read data.
// Depends on tsol_pkg for the entry type.
module tsol_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  tsol_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output tsol_pkg::entry_t rd_data
);

  tsol_pkg::entry_t mem [DEPTH];
  tsol_pkg::entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data valid in the cycle after the request.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/tsol_seq.sv
// Sequencer of the list: scans the entry memory one entry per cycle through a
// shared key comparator and count incrementer. Depends on tsol_pkg, tsol_if and the macros.
`include "transpose_self_organizing_list_core_macros.svh"

module tsol_seq #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  tsol_in_if.sink          in_if,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  tsol_pkg::entry_t rd_data,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output tsol_pkg::entry_t wr_data,
  output logic             res_valid,
  input  logic             res_ready,
  output tsol_pkg::res_t   res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SWAP  = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [CW-1:0]    total_r, total_nxt;
  logic [CW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]    cmp_idx_r, cmp_idx_nxt;
  tsol_pkg::entry_t prev_r, prev_nxt;
  logic [31:0]      cnt_r, cnt_nxt;
  tsol_pkg::res_t   res_r, res_nxt;

  logic             more;
  logic             match;
  logic [31:0]      inc_cnt;
  logic             insert_take;

  // Shared compare and saturating increment on the entry just read.
  assign more    = rd_ptr_r < total_r;
  assign match   = cmp_vld_r && (rd_data.key == key_r);
  assign inc_cnt = (rd_data.cnt == 32'hFFFF_FFFF) ? rd_data.cnt : rd_data.cnt + 32'd1;

  assign in_if.ready = (state_r == ST_IDLE);
  assign res_valid   = (state_r == ST_DONE);
  assign res         = res_r;
  assign rd_addr     = rd_ptr_r[AW-1:0];

  // Accepted insert with room left, for the length check.
  assign insert_take = in_if.ready && in_if.valid && (in_if.op == tsol_pkg::OP_INSERT) &&
                       (total_r != CW'(CAPACITY));

  // Next-state and datapath control.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    total_nxt   = total_r;
    rd_ptr_nxt  = rd_ptr_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    prev_nxt    = prev_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_r;
    wr_data     = prev_r;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          op_nxt      = in_if.op;
          key_nxt     = $unsigned(in_if.key);
          rd_ptr_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_DONE;
          res_nxt     = '{status: tsol_pkg::STAT_MISS, hit_count: 32'd0};
          case (in_if.op)
            tsol_pkg::OP_INSERT: begin
              if (total_r == CW'(CAPACITY)) begin
                res_nxt.status = tsol_pkg::STAT_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = total_r[AW-1:0];
                wr_data        = '{key: $unsigned(in_if.key), cnt: 32'd0};
                total_nxt      = total_r + 1'b1;
                res_nxt.status = tsol_pkg::STAT_OK;
              end
            end
            tsol_pkg::OP_DELETE, tsol_pkg::OP_SEARCH: begin
              if (total_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Stream reads from the head; compare each entry as it returns.
        if (more) begin
          rd_en       = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
          cmp_idx_nxt = rd_ptr_r[AW-1:0];
          cmp_vld_nxt = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (match) begin
          cmp_vld_nxt    = 1'b0;
          res_nxt.status = tsol_pkg::STAT_OK;
          if (op_r == tsol_pkg::OP_SEARCH) begin
            cnt_nxt           = inc_cnt;
            res_nxt.hit_count = inc_cnt;
            wr_en             = 1'b1;
            if (cmp_idx_r == '0) begin
              wr_addr   = '0;
              wr_data   = '{key: key_r, cnt: inc_cnt};
              state_nxt = ST_DONE;
            end else begin
              // Predecessor moves down now, the hit moves up next cycle.
              wr_addr     = cmp_idx_r;
              wr_data     = prev_r;
              cmp_idx_nxt = cmp_idx_r - 1'b1;
              state_nxt   = ST_SWAP;
            end
          end else begin
            rd_ptr_nxt = CW'(cmp_idx_r) + 1'b1;
            state_nxt  = ST_SHIFT;
          end
        end else if (cmp_vld_r) begin
          prev_nxt = rd_data;
        end else if (!more) begin
          state_nxt = ST_DONE;
        end
      end

      ST_SWAP: begin
        wr_en     = 1'b1;
        wr_addr   = cmp_idx_r;
        wr_data   = '{key: key_r, cnt: cnt_r};
        state_nxt = ST_DONE;
      end

      ST_SHIFT: begin
        // Each later entry is read and written back one place toward the head.
        if (more) begin
          rd_en       = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
          cmp_idx_nxt = rd_ptr_r[AW-1:0];
          cmp_vld_nxt = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (cmp_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = cmp_idx_r - 1'b1;
          wr_data = rd_data;
        end else if (!more) begin
          total_nxt = total_r - 1'b1;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      total_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    prev_r    <= prev_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
  end

  `TSOL_ASSERT_IMP(a_total_bound, clk, rst_n, 1'b1, total_r <= CW'(CAPACITY))
  `TSOL_ASSERT_IMP(a_read_in_list, clk, rst_n, rd_en, rd_ptr_r < total_r)
  `TSOL_ASSERT_NXT(a_insert_grows, clk, rst_n, insert_take, total_r == $past(total_r) + 1'b1)
  `TSOL_ASSERT_NXT(a_result_release, clk, rst_n, res_valid && res_ready, state_r == ST_IDLE)

endmodule

FILE: rtl/core/transpose_self_organizing_list_core.sv
// Transpose self-organizing list top level: sequencer, entry memory and output register.
// Insert writes the new entry at the tail at once; search reads the list from the head,
// one memory read per cycle, and on a hit not at the head swaps it with its predecessor;
// delete scans the same way and then closes the gap with a second read pass.
// Requests: one item at a time; the next is taken only after the result has left the sequencer.
// Reset (synchronous, rst_n low) empties the list and output register; no clearing pass.
module transpose_self_organizing_list_core #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  tsol_in_if.sink    in_if,
  tsol_out_if.source out_if
);

  localparam int AW = $clog2(CAPACITY);

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  tsol_pkg::entry_t rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  tsol_pkg::entry_t wr_data;
  logic             res_valid;
  logic             res_ready;
  tsol_pkg::res_t   res;

  logic             out_vld_r, out_vld_nxt;
  tsol_pkg::res_t   out_res_r, out_res_nxt;

  tsol_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tsol_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: takes a result when empty or when its transfer completes.
  assign res_ready = !out_vld_r || out_if.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (res_valid && res_ready) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.status    = out_res_r.status;
  assign out_if.hit_count = out_res_r.hit_count;

endmodule

FILE: dv/tsol_checker.sv
`timescale 1ns / 100ps
// Checker for the transpose self-organizing list: watches both channels, keeps its own
// copy of the list and compares every result transfer. Depends on tsol_pkg.
module tsol_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_key,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_hit_count,
  output int          fail_count,
  output int          pending,
  output int          done_seen,
  output int          miss_seen,
  output int          full_seen,
  output int          moved_hits
);

  // Shadow copy of the list, head at index 0.
  logic [31:0] list_keys   [CAPACITY];
  logic [31:0] list_counts [CAPACITY];
  int          list_len = 0;
  int          moved_total = 0;

  // Results owed by the block, oldest first.
  tsol_pkg::res_t awaited_results [$];

  int errors = 0;
  int n_done = 0;
  int n_miss = 0;
  int n_full = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    done_seen  = 0;
    miss_seen  = 0;
    full_seen  = 0;
    moved_hits = 0;
  end

  // First match counted from the head, or the list length when absent.
  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < list_len; i++) begin
      if (list_keys[i] == k) return i;
    end
    return list_len;
  endfunction

  function automatic logic [31:0] bump_count(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // Applies one request to the shadow list and returns the result it must produce.
  function automatic tsol_pkg::res_t apply_list_op(logic [1:0] op, logic [31:0] k);
    tsol_pkg::res_t r;
    int             pos;
    logic [31:0]    moved;
    r.status    = tsol_pkg::STAT_MISS;
    r.hit_count = '0;
    case (op)
      tsol_pkg::OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = tsol_pkg::STAT_FULL;
        end else begin
          list_keys[list_len]   = k;
          list_counts[list_len] = '0;
          list_len++;
          r.status = tsol_pkg::STAT_OK;
        end
      end
      tsol_pkg::OP_DELETE: begin
        pos = find_key(k);
        if (pos < list_len) begin
          // Close the gap by pulling later entries one place toward the head.
          for (int i = pos; i < list_len - 1; i++) begin
            list_keys[i]   = list_keys[i + 1];
            list_counts[i] = list_counts[i + 1];
          end
          list_len--;
          r.status = tsol_pkg::STAT_OK;
        end
      end
      tsol_pkg::OP_SEARCH: begin
        pos = find_key(k);
        if (pos < list_len) begin
          if (pos == 0) begin
            list_counts[0] = bump_count(list_counts[0]);
            r.hit_count    = list_counts[0];
          end else begin
            // Swap the hit with its predecessor; the moved key carries its count plus one, saturating.
            moved                = list_counts[pos];
            list_keys[pos]       = list_keys[pos - 1];
            list_counts[pos]     = list_counts[pos - 1];
            list_keys[pos - 1]   = k;
            list_counts[pos - 1] = bump_count(moved);
            r.hit_count          = list_counts[pos - 1];
            moved_total++;
          end
          r.status = tsol_pkg::STAT_OK;
        end
      end
      default: begin
        // The unused code leaves the list alone and reports a miss.
      end
    endcase
    return r;
  endfunction

  // Result transfers are matched first, then any request transfer at the same edge is queued.
  always @(posedge clk) begin : watch
    tsol_pkg::res_t oldest;
    if (!rst_n) begin
      awaited_results.delete();
      list_len = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d hit_count %0d", out_status, out_hit_count);
          errors++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_status != oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, out_status);
            errors++;
          end
          if (out_hit_count != oldest.hit_count) begin
            $error("hit_count: expected %0d, actual %0d", oldest.hit_count, out_hit_count);
            errors++;
          end
        end
        case (out_status)
          tsol_pkg::STAT_OK:   n_done++;
          tsol_pkg::STAT_MISS: n_miss++;
          tsol_pkg::STAT_FULL: n_full++;
          default:   ;
        endcase
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_list_op(in_op, in_key));
      end
    end
    fail_count <= errors;
    pending    <= awaited_results.size();
    done_seen  <= n_done;
    miss_seen  <= n_miss;
    full_seen  <= n_full;
    moved_hits <= moved_total;
  end

endmodule

FILE: dv/tb_transpose_self_organizing_list_core.sv
`timescale 1ns / 100ps
// Testbench top for the transpose self-organizing list: clock, reset, request and
// result drivers, and the verdict. Depends on tsol_pkg, tsol_if, tsol_checker and the core.
module tb_transpose_self_organizing_list_core;

  localparam int         CAPACITY     = 64;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  // Worst case per request is one pass over the list, the scan and the gap-closing pass together.
  localparam int         DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int         LONG_HOLD    = 400;
  localparam int         CYCLE_LIMIT  = 2_000_000;

  logic clk;
  logic rst_n;

  tsol_in_if  in_ch ();
  tsol_out_if out_ch ();

  int fail_count;
  int pending;
  int done_seen;
  int miss_seen;
  int full_seen;
  int moved_hits;

  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int hold_request      = 0;
  int requests_sent     = 0;
  int cycle_count       = 0;

  // Keys that recur often enough to produce hits, duplicates and a full list.
  logic [31:0] key_pool [10] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h0000_002A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1234_5678, 32'h0000_03E8
  };

  transpose_self_organizing_list_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  tsol_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_op        (in_ch.op),
    .in_key       (in_ch.key),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_hit_count(out_ch.hit_count),
    .fail_count   (fail_count),
    .pending      (pending),
    .done_seen    (done_seen),
    .miss_seen    (miss_seen),
    .full_seen    (full_seen),
    .moved_hits   (moved_hits)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_request = 0;
        hold_left    = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offers one request and returns at the edge where it is transferred.
  task automatic send_request(logic [1:0] op, logic [31:0] k);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.key   <= k;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 88) return key_pool[$urandom_range(9)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_op(int insert_w, int delete_w, int search_w);
    int r;
    r = $urandom_range(99);
    if (r < insert_w) return tsol_pkg::OP_INSERT;
    if (r < insert_w + delete_w) return tsol_pkg::OP_DELETE;
    if (r < insert_w + delete_w + search_w) return tsol_pkg::OP_SEARCH;
    return OP_UNUSED;
  endfunction

  // A run of random requests with the given mix of operations in percent.
  task automatic run_mix(int count, int insert_w, int delete_w, int search_w);
    for (int n = 0; n < count; n++) begin
      send_request(pick_op(insert_w, delete_w, search_w), pick_key());
    end
  endtask

  // Stimulus and verdict.
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.op    <= tsol_pkg::OP_INSERT;
    in_ch.key   <= '0;
    rst_n       <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list, the unused code, extreme keys, duplicates, head and moving hits.
    send_request(tsol_pkg::OP_SEARCH, 32'h0000_0000);
    send_request(tsol_pkg::OP_DELETE, 32'h0000_0005);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(tsol_pkg::OP_INSERT, 32'h8000_0000);
    send_request(tsol_pkg::OP_INSERT, 32'h7FFF_FFFF);
    send_request(tsol_pkg::OP_INSERT, 32'hFFFF_FFFF);
    send_request(tsol_pkg::OP_INSERT, 32'h0000_0000);
    send_request(tsol_pkg::OP_INSERT, 32'h7FFF_FFFF);
    send_request(tsol_pkg::OP_SEARCH, 32'h8000_0000);
    send_request(tsol_pkg::OP_SEARCH, 32'h8000_0000);
    send_request(tsol_pkg::OP_SEARCH, 32'h0000_0000);
    send_request(tsol_pkg::OP_SEARCH, 32'h0000_0000);
    send_request(tsol_pkg::OP_SEARCH, 32'h0000_0000);
    send_request(tsol_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    send_request(tsol_pkg::OP_SEARCH, 32'h1234_5678);
    send_request(tsol_pkg::OP_DELETE, 32'h7FFF_FFFF);
    send_request(tsol_pkg::OP_DELETE, 32'h0000_0000);
    send_request(tsol_pkg::OP_DELETE, 32'h7FFF_FFFF);
    send_request(tsol_pkg::OP_DELETE, 32'h7FFF_FFFF);
    send_request(OP_UNUSED, 32'h7FFF_FFFF);
    send_request(tsol_pkg::OP_SEARCH, 32'hFFFF_FFFF);

    // Random phases: fill toward full, churn with searches, then drain with deletes.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          hold_request       = 1;
        end
        1: begin
          sender_idle_pct    = 48;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 48;
        end
        default: begin
          sender_idle_pct    = 26;
          receiver_stall_pct = 26;
        end
      endcase
      run_mix(70, 88, 6, 5);
      run_mix(50, 10, 15, 70);
      run_mix(30, 5, 80, 13);
    end

    // Let the checker see the last request, wait for every owed result, then allow
    // for any late extra transfer.
    in_ch.valid <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests sent; results: %0d done or found, %0d miss, %0d full",
             requests_sent, done_seen, miss_seen, full_seen);
    $display("tb: %0d search hits moved an entry toward the head", moved_hits);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: transpose_self_organizing_list_core.f
+incdir+rtl/core
rtl/core/tsol_pkg.sv
rtl/core/tsol_if.sv
rtl/core/tsol_ram.sv
rtl/core/tsol_seq.sv
rtl/core/transpose_self_organizing_list_core.sv
dv/tsol_checker.sv
dv/tb_transpose_self_organizing_list_core.sv
